// ===== hw/rtl/raycast_wall_column_texturer_core_defines.svh =====
// Assertion macros shared by the wall column texturer RTL.
`ifndef RAYCAST_WALL_COLUMN_TEXTURER_CORE_DEFINES_SVH
`define RAYCAST_WALL_COLUMN_TEXTURER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RWCT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rwct assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RWCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rwct assertion failed");

`endif

// ===== hw/rtl/rwct_pkg.sv =====
// Shared types and constants for the wall column texturer.
package rwct_pkg;

    localparam int COL_W     = 12;   // screen column / row / texel output width
    localparam int DIM_W     = 13;   // texture dimensions and screen height
    localparam int DIST_W    = 32;
    localparam int HFRAC_W   = 16;   // hit fractions, 0.16
    localparam int SIDE_W    = 2;
    localparam int H_W       = 31;   // wall height, saturates at INT_MAX
    localparam int CFG_IDX_W = 1;

    localparam logic [H_W-1:0]   INT_MAX_H   = {H_W{1'b1}};
    localparam logic [DIM_W-1:0] TEX_DIM_RST = 13'd64;

    // command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = 1'b1;

    // hit side bits: bit 1 selects the y fraction, bit 0 clear mirrors it
    localparam int SIDE_Y_BIT   = 1;
    localparam int SIDE_FWD_BIT = 0;

    typedef struct packed {
        logic load;          // start transfer: latch fields, drop old span
        logic pixel;         // pixel transfer
        logic h_inf;         // zero distance: height saturates
        logic div_start;
        logic div_sel;       // 0 height division, 1 step division
        logic h_capture;
        logic step_capture;
        logic mul_capture;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic dist_zero;
        logic h_zero;
        logic out_valid;
    } t_dp_sts;

endpackage

// ===== hw/rtl/rwct_channels.sv =====
// Valid/ready channel interfaces for column items and pixel results.
interface rwct_item_if;
    logic                               valid;
    logic                               ready;
    logic                               command;
    logic [rwct_pkg::COL_W-1:0]         column;
    logic [rwct_pkg::DIST_W-1:0]        distance;
    logic [rwct_pkg::SIDE_W-1:0]        hit_face;
    logic [rwct_pkg::HFRAC_W-1:0]       hit_frac_x;
    logic [rwct_pkg::HFRAC_W-1:0]       hit_frac_y;
    logic                               shade;

    modport source (output valid, command, column, distance, hit_face,
                    hit_frac_x, hit_frac_y, shade, input ready);
    modport sink   (input valid, command, column, distance, hit_face,
                    hit_frac_x, hit_frac_y, shade, output ready);
endinterface

interface rwct_pixel_if;
    logic                          valid;
    logic                          ready;
    logic [rwct_pkg::COL_W-1:0]    pixel_column;
    logic [rwct_pkg::COL_W-1:0]    pixel_row;
    logic [rwct_pkg::COL_W-1:0]    texel_x;
    logic [rwct_pkg::COL_W-1:0]    texel_y;
    logic                          pixel_dark;
    logic                          last;

    modport source (output valid, pixel_column, pixel_row, texel_x, texel_y,
                    pixel_dark, last, input ready);
    modport sink   (input valid, pixel_column, pixel_row, texel_x, texel_y,
                    pixel_dark, last, output ready);
endinterface

// ===== hw/rtl/raycast_wall_column_texturer_core.sv =====
// Top level of the textured wall column stepper for a raycaster.
//
// A start transfer (command 0) turns the ray's perpendicular distance
// (unsigned, FRAC_BITS fraction bits) into a wall height of
// SCREEN_HEIGHT / distance, saturating at 2^31-1 for tiny or zero
// distances; a height below one opens no span. It also latches the texture
// column (from hit side and hit fraction, clamped to width-1, zero for a
// zero-width texture), the per-row texture step, and the vertical span:
// centered with the texture starting at row 0 for short walls, or the whole
// screen with a centered texture offset for tall ones. Each pixel transfer
// (command 1) then yields one pixel, top to bottom, with "last" set on the
// bottom row; a pixel transfer with no live span yields nothing, and a new
// start drops any span still in progress. Texture size is taken from the
// config registers at the start transfer.
//
// Timing: pixel transfers go at one per cycle while the sink keeps up. A
// pixel held in the output register blocks the item channel until it is
// taken; the next item can enter in the same cycle the pixel leaves.
// A start transfer occupies the block while the shared one-bit-per-cycle
// divider runs twice, once for the height and once for the texture step;
// no item is taken meanwhile. A start that ends with no span returns after
// the height divide. Config writes are accepted in any cycle.
module raycast_wall_column_texturer_core #(
    parameter int SCREEN_HEIGHT = 480,
    parameter int FRAC_BITS     = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rwct_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rwct_pkg::DIM_W-1:0]         i_cfg_wdata,
    rwct_item_if.sink                          i_item,
    rwct_pixel_if.source                       o_pixel
);
    rwct_pkg::t_dp_cmd w_cmd;   // sequencer -> datapath
    rwct_pkg::t_dp_sts w_sts;   // datapath -> sequencer

    // handshake and setup sequencing
    rwct_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_item.valid),
        .i_in_command (i_item.command),
        .i_out_ready  (o_pixel.ready),
        .i_sts        (w_sts),
        .o_in_ready   (i_item.ready),
        .o_cmd        (w_cmd)
    );

    // arithmetic, span state and the output register
    rwct_dp #(
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .FRAC_BITS     (FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_column       (i_item.column),
        .i_distance     (i_item.distance),
        .i_hit_face     (i_item.hit_face),
        .i_hit_frac_x   (i_item.hit_frac_x),
        .i_hit_frac_y   (i_item.hit_frac_y),
        .i_shade        (i_item.shade),
        .i_out_ready    (o_pixel.ready),
        .o_out_valid    (o_pixel.valid),
        .o_pixel_column (o_pixel.pixel_column),
        .o_pixel_row    (o_pixel.pixel_row),
        .o_texel_x      (o_pixel.texel_x),
        .o_texel_y      (o_pixel.texel_y),
        .o_pixel_dark   (o_pixel.pixel_dark),
        .o_last         (o_pixel.last)
    );
endmodule

// ===== hw/rtl/rwct_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module rwct_div #(
    parameter int NUM_W = 29,
    parameter int DEN_W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);
    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic [NUM_W-1:0] r_num;   // dividend shifts out, quotient shifts in
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0] w_trial;
    logic [DEN_W:0] w_diff;
    logic           w_ge;

    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
            r_cnt <= CNT_W'(NUM_W - 1);
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_num <= {r_num[NUM_W-2:0], w_ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_num;
endmodule

// ===== hw/rtl/rwct_ctrl.sv =====
// Sequencer: input handshake and start-item setup steps.
`include "raycast_wall_column_texturer_core_defines.svh"

module rwct_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_command,
    input  logic              i_out_ready,
    input  rwct_pkg::t_dp_sts i_sts,
    output logic              o_in_ready,
    output rwct_pkg::t_dp_cmd o_cmd
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_HGO    = 3'd1;
    localparam logic [2:0] S_HWAIT  = 3'd2;
    localparam logic [2:0] S_HTEST  = 3'd3;
    localparam logic [2:0] S_SWAIT  = 3'd4;
    localparam logic [2:0] S_MUL    = 3'd5;
    localparam logic [2:0] S_COMMIT = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_accept;

    assign o_in_ready = (r_state == S_IDLE) && (!i_sts.out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_command == rwct_pkg::CMD_START) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_HGO;
                    end else begin
                        o_cmd.pixel = 1'b1;
                    end
                end
            end
            S_HGO: begin
                if (i_sts.dist_zero) begin
                    o_cmd.h_inf = 1'b1;
                    n_state     = S_HTEST;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_HWAIT;
                end
            end
            S_HWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.h_capture = 1'b1;
                    n_state         = S_HTEST;
                end
            end
            S_HTEST: begin
                if (i_sts.h_zero) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = 1'b1;
                    n_state         = S_SWAIT;
                end
            end
            S_SWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.step_capture = 1'b1;
                    n_state            = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_capture = 1'b1;
                n_state           = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `RWCT_ASSERT_IMPL(a_div_free, i_clk, i_rst_n, o_cmd.div_start, !i_sts.div_busy)
    `RWCT_ASSERT_NEXT(a_start_blocks, i_clk, i_rst_n, o_cmd.load, !o_in_ready)
endmodule

// ===== hw/rtl/rwct_dp.sv =====
// Datapath: config registers, height/step math, span stepper, output register.
`include "raycast_wall_column_texturer_core_defines.svh"

module rwct_dp #(
    parameter int SCREEN_HEIGHT = 480,
    parameter int FRAC_BITS     = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  rwct_pkg::t_dp_cmd                  i_cmd,
    output rwct_pkg::t_dp_sts                  o_sts,
    input  logic                               i_cfg_we,
    input  logic [rwct_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rwct_pkg::DIM_W-1:0]         i_cfg_wdata,
    input  logic [rwct_pkg::COL_W-1:0]         i_column,
    input  logic [rwct_pkg::DIST_W-1:0]        i_distance,
    input  logic [rwct_pkg::SIDE_W-1:0]        i_hit_face,
    input  logic [rwct_pkg::HFRAC_W-1:0]       i_hit_frac_x,
    input  logic [rwct_pkg::HFRAC_W-1:0]       i_hit_frac_y,
    input  logic                               i_shade,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [rwct_pkg::COL_W-1:0]         o_pixel_column,
    output logic [rwct_pkg::COL_W-1:0]         o_pixel_row,
    output logic [rwct_pkg::COL_W-1:0]         o_texel_x,
    output logic [rwct_pkg::COL_W-1:0]         o_texel_y,
    output logic                               o_pixel_dark,
    output logic                               o_last
);
    localparam int DIM_W  = rwct_pkg::DIM_W;
    localparam int COL_W  = rwct_pkg::COL_W;
    localparam int H_W    = rwct_pkg::H_W;
    localparam int HF_W   = rwct_pkg::HFRAC_W;
    localparam int NUM_W  = FRAC_BITS + DIM_W;    // dividend width for both divides
    localparam int ACC_W  = FRAC_BITS + COL_W;    // texture row accumulator, mod 2^ACC_W
    localparam int QX_W   = (NUM_W > 32) ? NUM_W : 32;
    localparam int F_W    = HF_W + 1;
    localparam int PROD_W = F_W + DIM_W;

    // configuration
    logic [DIM_W-1:0] r_cfg_tw;
    logic [DIM_W-1:0] r_cfg_th;

    // fields latched on a start transfer
    logic [COL_W-1:0]                r_col;
    logic                            r_dark;
    logic [rwct_pkg::SIDE_W-1:0]     r_side;
    logic [HF_W-1:0]                 r_fx;
    logic [HF_W-1:0]                 r_fy;
    logic [rwct_pkg::DIST_W-1:0]     r_dist;
    logic [DIM_W-1:0]                r_tw;
    logic [DIM_W-1:0]                r_th;

    // setup results
    logic [PROD_W-1:0] r_prod;
    logic [H_W-1:0]    r_h;
    logic [NUM_W-1:0]  r_step;
    logic [NUM_W-1:0]  r_sprod;

    // live span
    logic              r_active;
    logic [DIM_W-1:0]  r_row;
    logic [DIM_W-1:0]  r_end;
    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  r_inc;
    logic [COL_W-1:0]  r_tx;
    logic [COL_W-1:0]  r_scol;
    logic              r_sdark;

    // output register
    logic              r_out_valid;
    logic [COL_W-1:0]  r_o_col;
    logic [COL_W-1:0]  r_o_row;
    logic [COL_W-1:0]  r_o_tx;
    logic [COL_W-1:0]  r_o_ty;
    logic              r_o_dark;
    logic              r_o_last;

    logic [NUM_W-1:0]            w_div_num;
    logic [rwct_pkg::DIST_W-1:0] w_div_den;
    logic [NUM_W-1:0]            w_quo;
    logic                        w_div_busy;
    logic                        w_div_done;
    logic [QX_W-1:0]             w_q_ext;
    logic [NUM_W-1:0]            w_tex_num;
    logic [NUM_W-1:0]            w_diff;
    logic [F_W-1:0]              w_frac;
    logic [DIM_W:0]              w_t;
    logic [DIM_W:0]              w_tw_m1;
    logic [DIM_W:0]              w_tx;
    logic [DIM_W-1:0]            w_sh;
    logic [DIM_W-1:0]            w_h_lo;
    logic [DIM_W-1:0]            w_row0;
    logic                        w_short;
    logic                        w_fin;
    logic                        w_emit;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_tw <= rwct_pkg::TEX_DIM_RST;
            r_cfg_th <= rwct_pkg::TEX_DIM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rwct_pkg::CFG_TEX_WIDTH:  r_cfg_tw <= i_cfg_wdata;
                rwct_pkg::CFG_TEX_HEIGHT: r_cfg_th <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // texture column: pick fraction, mirror on north/east, scale by width
    always_comb begin
        w_frac = r_side[rwct_pkg::SIDE_Y_BIT] ? {1'b0, r_fy} : {1'b0, r_fx};
        if (!r_side[rwct_pkg::SIDE_FWD_BIT]) begin
            w_frac = {1'b1, {HF_W{1'b0}}} - w_frac;
        end
    end

    assign w_t     = r_prod[PROD_W-1:HF_W];
    assign w_tw_m1 = {1'b0, r_tw} - 1'b1;
    assign w_tx    = (r_tw == '0) ? '0 : ((w_t > w_tw_m1) ? w_tw_m1 : w_t);

    // shared divider operands
    assign w_tex_num = {r_th, {FRAC_BITS{1'b0}}};
    assign w_div_num = i_cmd.div_sel ? w_tex_num
                                     : {DIM_W'(SCREEN_HEIGHT), {FRAC_BITS{1'b0}}};
    assign w_div_den = i_cmd.div_sel ? {1'b0, r_h} : r_dist;
    assign w_q_ext   = QX_W'(w_quo);

    rwct_div #(
        .NUM_W (NUM_W),
        .DEN_W (rwct_pkg::DIST_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // span geometry
    assign w_sh    = DIM_W'(SCREEN_HEIGHT);
    assign w_h_lo  = r_h[DIM_W-1:0];
    assign w_short = (r_h < H_W'(SCREEN_HEIGHT));
    assign w_row0  = (w_sh - w_h_lo) >> 1;
    assign w_diff  = w_tex_num - r_sprod;

    assign w_fin  = (({1'b0, r_row} + 1'b1) >= {1'b0, r_end});
    assign w_emit = i_cmd.pixel && r_active;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_col  <= i_column;
            r_dark <= i_shade;
            r_side <= i_hit_face;
            r_fx   <= i_hit_frac_x;
            r_fy   <= i_hit_frac_y;
            r_dist <= i_distance;
            r_tw   <= r_cfg_tw;
            r_th   <= r_cfg_th;
        end
        r_prod <= PROD_W'(w_frac) * PROD_W'(r_tw);
        if (i_cmd.h_inf) begin
            r_h <= rwct_pkg::INT_MAX_H;
        end else if (i_cmd.h_capture) begin
            r_h <= (w_q_ext > QX_W'(rwct_pkg::INT_MAX_H)) ? rwct_pkg::INT_MAX_H
                                                          : w_q_ext[H_W-1:0];
        end
        if (i_cmd.step_capture) begin
            r_step <= w_quo;
        end
        if (i_cmd.mul_capture) begin
            r_sprod <= NUM_W'(r_step * NUM_W'(SCREEN_HEIGHT));
        end
        if (i_cmd.commit) begin
            r_scol  <= r_col;
            r_sdark <= r_dark;
            r_tx    <= w_tx[COL_W-1:0];
            r_inc   <= r_step[ACC_W-1:0];
            if (w_short) begin
                r_row <= w_row0;
                r_end <= w_row0 + w_h_lo;
                r_acc <= '0;
            end else begin
                r_row <= '0;
                r_end <= w_sh;
                r_acc <= w_diff[NUM_W-1:1];
            end
        end else if (w_emit) begin
            r_row <= r_row + 1'b1;
            r_acc <= r_acc + r_inc;
        end
        if (w_emit) begin
            r_o_col  <= r_scol;
            r_o_row  <= r_row[COL_W-1:0];
            r_o_tx   <= r_tx;
            r_o_ty   <= r_acc[ACC_W-1:FRAC_BITS];
            r_o_dark <= r_sdark;
            r_o_last <= w_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_active <= 1'b0;
            end else if (i_cmd.commit) begin
                r_active <= 1'b1;
            end else if (w_emit && w_fin) begin
                r_active <= 1'b0;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.div_busy  = w_div_busy;
    assign o_sts.div_done  = w_div_done;
    assign o_sts.dist_zero = (r_dist == '0);
    assign o_sts.h_zero    = (r_h == '0);
    assign o_sts.out_valid = r_out_valid;

    assign o_out_valid    = r_out_valid;
    assign o_pixel_column = r_o_col;
    assign o_pixel_row    = r_o_row;
    assign o_texel_x      = r_o_tx;
    assign o_texel_y      = r_o_ty;
    assign o_pixel_dark   = r_o_dark;
    assign o_last         = r_o_last;

    `RWCT_ASSERT_IMPL(a_span_in_range, i_clk, i_rst_n, r_active, r_row < r_end)
    `RWCT_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, w_emit, !r_out_valid || i_out_ready)
    `RWCT_ASSERT_NEXT(a_last_closes, i_clk, i_rst_n, w_emit && w_fin, !r_active)
endmodule

// ===== sim/tb_raycast_wall_column_texturer_core.sv =====
// Self-checking testbench for the raycast wall column texturer core.
`timescale 1ns / 100ps

module tb_raycast_wall_column_texturer_core;

    // DUT build parameters; the predictor uses the same values.
    localparam int          SCREEN_H   = 480;
    localparam int          FRAC       = 16;
    localparam logic [63:0] SCREEN_H64 = 64'd480;
    // SCREEN_H << FRAC: the distance that gives a wall height of exactly one row.
    localparam int unsigned HEIGHT_NUM = 32'd31457280;
    // A start holds the block while its divides run; settle time before cfg writes.
    localparam int          SETTLE     = 150;
    // Cycles with no transfer on either channel before the run is declared hung.
    localparam int          HANG_LIMIT = 5000;

    // hit face codes
    localparam logic [1:0] FACE_N = 2'd0;
    localparam logic [1:0] FACE_S = 2'd1;
    localparam logic [1:0] FACE_E = 2'd2;
    localparam logic [1:0] FACE_W = 2'd3;

    typedef struct packed {
        logic        command;
        logic [11:0] column;
        logic [31:0] distance;
        logic [1:0]  hit_face;
        logic [15:0] hit_frac_x;
        logic [15:0] hit_frac_y;
        logic        shade;
    } t_item;

    typedef struct packed {
        logic [11:0] pixel_column;
        logic [11:0] pixel_row;
        logic [11:0] texel_x;
        logic [11:0] texel_y;
        logic        pixel_dark;
        logic        last;
    } t_pixel;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_we    = 1'b0;
    logic [rwct_pkg::CFG_IDX_W-1:0] i_cfg_idx   = rwct_pkg::CFG_TEX_WIDTH;
    logic [rwct_pkg::DIM_W-1:0]     i_cfg_wdata = '0;

    rwct_item_if  item_ch ();
    rwct_pixel_if pix_ch ();

    raycast_wall_column_texturer_core #(
        .SCREEN_HEIGHT (SCREEN_H),
        .FRAC_BITS     (FRAC)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (item_ch),
        .o_pixel     (pix_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shared state
    // ------------------------------------------------------------------
    t_item  items_to_send[$];   // stimulus waiting for the driver
    t_pixel pixels_due[$];      // predicted pixels, oldest first
    t_item  in_flight;          // item currently presented on the item channel
    int     errors       = 0;
    int     items_queued = 0;   // counts starts and ticks that make a pixel
    int     src_idle_pct = 0;
    int     snk_stall_pct = 0;
    int     idle_cycles  = 0;

    // Texture size as last written; latched into a column on its start.
    logic [12:0] tex_w = rwct_pkg::TEX_DIM_RST;
    logic [12:0] tex_h = rwct_pkg::TEX_DIM_RST;

    // Live span of the column being drawn.
    logic        span_live = 1'b0;
    logic [63:0] span_col, span_row, span_stop, span_acc, span_step, span_tx;
    logic        span_dark;

    task automatic note_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Column predictor
    // ------------------------------------------------------------------
    // Texture column from hit face: bit 1 picks the y fraction, bit 0 clear
    // mirrors it (north/east read 1 - frac). A result equal to the width
    // is pulled back onto the last texel; a zero-width texture gives 0.
    function automatic logic [63:0] wall_texel_x(t_item it);
        logic [63:0] w, f, t;
        w = 64'(tex_w);
        if (w == 0)
            return 64'd0;
        f = it.hit_face[rwct_pkg::SIDE_Y_BIT] ? 64'(it.hit_frac_y) : 64'(it.hit_frac_x);
        if (!it.hit_face[rwct_pkg::SIDE_FWD_BIT])
            f = 64'd65536 - f;
        t = (f * w) >> 16;
        if (t > w - 1)
            t = w - 1;
        return t;
    endfunction

    // Start transfer: wall height, step, span placement. Any live span is dropped.
    function automatic void latch_column(t_item it);
        logic [63:0] h, th;
        th = 64'(tex_h);
        span_live = 1'b0;
        if (it.distance == 0) begin
            h = 64'(rwct_pkg::INT_MAX_H);
        end else begin
            h = (SCREEN_H64 << FRAC) / 64'(it.distance);
            if (h > 64'(rwct_pkg::INT_MAX_H))
                h = 64'(rwct_pkg::INT_MAX_H);
        end
        if (h == 0)
            return;    // too far: no span at all
        span_col  = 64'(it.column);
        span_dark = it.shade;
        span_tx   = wall_texel_x(it);
        span_step = (th << FRAC) / h;
        if (h < SCREEN_H64) begin
            // short wall, centered, texture from row 0
            span_row  = (SCREEN_H64 - h) / 2;
            span_stop = span_row + h;
            span_acc  = 64'd0;
        end else begin
            // tall wall fills the screen, texture offset keeps it centered
            span_row  = 64'd0;
            span_stop = SCREEN_H64;
            span_acc  = ((th << FRAC) - span_step * SCREEN_H64) / 2;
        end
        span_live = 1'b1;
    endfunction

    // Pixel transfer on a live span: emit the current row and advance.
    function automatic t_pixel next_pixel();
        t_pixel p;
        logic   fin;
        fin            = (span_row + 1 >= span_stop);
        p.pixel_column = span_col[11:0];
        p.pixel_row    = span_row[11:0];
        p.texel_x      = span_tx[11:0];
        p.texel_y      = 12'(span_acc >> FRAC);
        p.pixel_dark   = span_dark;
        p.last         = fin;
        span_acc       = span_acc + span_step;
        span_row       = span_row + 1;
        if (fin)
            span_live = 1'b0;
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued items, predicts at each accepted transfer
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                if (in_flight.command == rwct_pkg::CMD_START)
                    latch_column(in_flight);
                else if (span_live)
                    pixels_due.push_back(next_pixel());
                // a tick with no live span yields nothing
            end
            // Slot is free when nothing is shown or the shown item just went.
            if (!item_ch.valid || item_ch.ready) begin
                if (items_to_send.size() != 0 &&
                    $urandom_range(99) >= src_idle_pct) begin
                    in_flight = items_to_send.pop_front();
                    item_ch.valid      <= 1'b1;
                    item_ch.command    <= in_flight.command;
                    item_ch.column     <= in_flight.column;
                    item_ch.distance   <= in_flight.distance;
                    item_ch.hit_face   <= in_flight.hit_face;
                    item_ch.hit_frac_x <= in_flight.hit_frac_x;
                    item_ch.hit_frac_y <= in_flight.hit_frac_y;
                    item_ch.shade      <= in_flight.shade;
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random backpressure, checks each pixel transfer
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            note_error($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            pix_ch.ready <= 1'b0;
        end else begin
            if (pix_ch.valid && pix_ch.ready) begin
                if (pixels_due.size() == 0) begin
                    note_error($sformatf("unexpected pixel col %0d row %0d",
                                         pix_ch.pixel_column, pix_ch.pixel_row));
                end else begin
                    want = pixels_due.pop_front();
                    check_field("pixel_column", pix_ch.pixel_column, want.pixel_column);
                    check_field("pixel_row", pix_ch.pixel_row, want.pixel_row);
                    check_field("texel_x", pix_ch.texel_x, want.texel_x);
                    check_field("texel_y", pix_ch.texel_y, want.texel_y);
                    check_field("pixel_dark", pix_ch.pixel_dark, want.pixel_dark);
                    check_field("last", pix_ch.last, want.last);
                end
            end
            pix_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: no transfer on either channel for too long means a hang
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (item_ch.valid && item_ch.ready) ||
            (pix_ch.valid && pix_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= HANG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", HANG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(input logic cmd, input logic [11:0] col,
                             input logic [31:0] d, input logic [1:0] face,
                             input logic [15:0] fx, input logic [15:0] fy,
                             input logic shd);
        items_to_send.push_back(t_item'{cmd, col, d, face, fx, fy, shd});
    endtask

    // Tick with random payload; the payload is ignored on a pixel request.
    task automatic push_tick();
        push_item(rwct_pkg::CMD_PIXEL, 12'($urandom), $urandom, 2'($urandom),
                  16'($urandom), 16'($urandom), 1'($urandom));
    endtask

    // One column: a start with random content, then a run of ticks. Most runs
    // cover the span exactly, some stop short (next start drops the span),
    // some overrun by one (tick with nothing live).
    task automatic queue_column();
        int          kind, h, rows, ticks;
        logic [31:0] d;
        kind = $urandom_range(99);
        if (kind < 6) begin
            d = $urandom_range(32'hFFFF_FFFF, HEIGHT_NUM + 1);    // too far
            h = 0;
        end else if (kind < 10) begin
            d = 32'd0;                                          // saturated height
            h = SCREEN_H;
        end else if (kind < 22) begin
            d = $urandom_range(65535, 1);                       // full-screen wall
            h = SCREEN_H;
        end else begin
            if (kind < 50)
                h = $urandom_range(8, 1);
            else if (kind < 85)
                h = $urandom_range(60, 9);
            else
                h = $urandom_range(SCREEN_H - 1, 61);
            // any distance in this range truncates to exactly h rows
            d = $urandom_range(HEIGHT_NUM / h, HEIGHT_NUM / (h + 1) + 1);
        end
        rows = h;
        if (h == 0)
            ticks = $urandom_range(2, 0);
        else if (h >= SCREEN_H && $urandom_range(3) != 0)
            ticks = $urandom_range(24, 1);
        else if ($urandom_range(9) < 3)
            ticks = $urandom_range(rows - 1, 0);
        else
            ticks = rows + ($urandom_range(4) == 0);
        push_item(rwct_pkg::CMD_START, 12'($urandom), d, 2'($urandom),
                  16'($urandom), 16'($urandom), 1'($urandom));
        repeat (ticks) push_tick();
        items_queued += 1 + ((ticks < rows) ? ticks : rows);
    endtask

    task automatic write_cfg(input logic [rwct_pkg::CFG_IDX_W-1:0] idx,
                             input logic [12:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        if (idx == rwct_pkg::CFG_TEX_WIDTH)
            tex_w = val;
        else
            tex_h = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every item went out and every predicted pixel came back,
    // then give a trailing start time to finish its divides.
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (items_to_send.size() != 0 || item_ch.valid || pixels_due.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [12:0] w, input logic [12:0] h,
                             input int src_pct, input int snk_pct, input int n_items);
        write_cfg(rwct_pkg::CFG_TEX_WIDTH, w);
        write_cfg(rwct_pkg::CFG_TEX_HEIGHT, h);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        items_queued  = 0;
        while (items_queued < n_items)
            queue_column();
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        item_ch.valid      = 1'b0;
        item_ch.command    = rwct_pkg::CMD_PIXEL;
        item_ch.column     = '0;
        item_ch.distance   = '0;
        item_ch.hit_face   = '0;
        item_ch.hit_frac_x = '0;
        item_ch.hit_frac_y = '0;
        item_ch.shade      = 1'b0;
        pix_ch.ready       = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: corner cases at reset texture size, no idling.
        write_cfg(rwct_pkg::CFG_TEX_WIDTH, rwct_pkg::TEX_DIM_RST);
        write_cfg(rwct_pkg::CFG_TEX_HEIGHT, rwct_pkg::TEX_DIM_RST);
        push_tick();                                                 // nothing live
        push_item(rwct_pkg::CMD_START, 12'd100, 32'hFFFF_FFFF, FACE_N,
                  16'h1234, 16'h0000, 1'b0);
        push_tick();                                                 // too far: no span
        // one-row wall; north face at frac 0 lands on the texture edge
        push_item(rwct_pkg::CMD_START, 12'hFFF, HEIGHT_NUM, FACE_N,
                  16'h0000, 16'h0000, 1'b1);
        push_tick();
        push_tick();
        // three rows, south face
        push_item(rwct_pkg::CMD_START, 12'h000, HEIGHT_NUM / 3, FACE_S,
                  16'hFFFF, 16'h0000, 1'b0);
        push_tick();
        push_tick();
        // zero distance on a live span: span replaced, height saturates; east edge
        push_item(rwct_pkg::CMD_START, 12'h5A5, 32'd0, FACE_E, 16'h0000, 16'h0000, 1'b1);
        repeat (3) push_tick();
        // smallest nonzero distance, west face
        push_item(rwct_pkg::CMD_START, 12'hA5A, 32'd1, FACE_W, 16'h0000, 16'hFFFF, 1'b0);
        repeat (2) push_tick();
        // two rows, then one tick past the end
        push_item(rwct_pkg::CMD_START, 12'd7, HEIGHT_NUM / 2, FACE_W,
                  16'hFFFF, 16'h8000, 1'b1);
        repeat (3) push_tick();
        wait_drained();

        // Random phases across texture sizes and idling patterns.
        run_phase(rwct_pkg::TEX_DIM_RST, rwct_pkg::TEX_DIM_RST, 0, 0, 160);
        run_phase(13'd1, 13'd1, 82, 0, 160);
        run_phase(13'd4096, 13'd4096, 0, 82, 160);
        run_phase(13'd0, 13'd0, 6, 6, 160);             // zero-size texture
        run_phase(13'd4095, 13'($urandom_range(4096, 1)), 0, 0, 80);

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
